/* design/ltlb_pkg.sv */
// ltlb_pkg: shared constants, types and FSM encoding for the LRU TLB miss counter.
// No dependencies; used by ltlb_dp, ltlb_ctrl and the top level.
package ltlb_pkg;

  localparam int ENTRIES    = 20;
  localparam int PAGE_SHIFT = 14;
  localparam int ADDR_BITS  = 48;
  localparam int TAG_BITS   = ADDR_BITS - PAGE_SHIFT;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_BITS  = IDX_BITS;
  localparam int CNT_BITS   = 32;
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);
  localparam logic [RANK_BITS-1:0] OLDEST_RANK = RANK_BITS'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

/* design/ltlb_ram.sv */
// ltlb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/ltlb_dp.sv */
// ltlb_dp: TLB datapath - tag RAM, valid bits, recency ranks, scan logic, miss counter,
// output register. Depends on ltlb_pkg and ltlb_ram; driven by ltlb_ctrl commands.
module ltlb_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ltlb_pkg::cmd_t                   cmd,
  output ltlb_pkg::stat_t                  stat,
  input  logic [ltlb_pkg::ADDR_BITS-1:0]   in_byte_address,
  output logic                             out_was_hit,
  output logic [ltlb_pkg::CNT_BITS-1:0]    out_total_misses
);

  logic [ltlb_pkg::TAG_BITS-1:0]  page_r;
  logic [ltlb_pkg::IDX_BITS-1:0]  idx_r;
  logic [ltlb_pkg::IDX_BITS-1:0]  cmp_idx_r;
  logic                           cmp_vld_r;
  logic                           hit_found_r;
  logic [ltlb_pkg::IDX_BITS-1:0]  hit_idx_r;
  logic [ltlb_pkg::RANK_BITS-1:0] hit_rank_r;
  logic                           free_found_r;
  logic [ltlb_pkg::IDX_BITS-1:0]  free_idx_r;
  logic                           vic_seen_r;
  logic [ltlb_pkg::IDX_BITS-1:0]  vic_idx_r;
  logic [ltlb_pkg::RANK_BITS-1:0] vic_rank_r;
  logic                           valid_r [ltlb_pkg::ENTRIES];
  logic [ltlb_pkg::RANK_BITS-1:0] rank_r  [ltlb_pkg::ENTRIES];
  logic [ltlb_pkg::CNT_BITS-1:0]  miss_cnt_r;
  logic                           out_hit_r;
  logic [ltlb_pkg::CNT_BITS-1:0]  out_cnt_r;

  logic [ltlb_pkg::TAG_BITS-1:0]  rd_tag;
  logic                           cur_valid;
  logic [ltlb_pkg::RANK_BITS-1:0] cur_rank;
  logic                           tag_eq;
  logic [ltlb_pkg::IDX_BITS-1:0]  slot;
  logic                           tag_we;

  assign cur_valid = valid_r[cmp_idx_r];
  assign cur_rank  = rank_r[cmp_idx_r];
  assign tag_eq    = (rd_tag == page_r);
  assign slot      = hit_found_r  ? hit_idx_r  :
                     free_found_r ? free_idx_r : vic_idx_r;
  assign tag_we    = cmd.update && !hit_found_r;

  assign stat.scan_last = (idx_r == ltlb_pkg::LAST_IDX);

  ltlb_ram #(
    .WIDTH (ltlb_pkg::TAG_BITS),
    .DEPTH (ltlb_pkg::ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (slot),
    .wdata (page_r),
    .raddr (idx_r),
    .rdata (rd_tag)
  );

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_r <= in_byte_address[ltlb_pkg::ADDR_BITS-1:ltlb_pkg::PAGE_SHIFT];
    end
    cmp_idx_r <= idx_r;
    if (cmd.load_out) begin
      out_hit_r <= hit_found_r;
      out_cnt_r <= miss_cnt_r;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      hit_idx_r    <= '0;
      hit_rank_r   <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      vic_seen_r   <= 1'b0;
      vic_idx_r    <= '0;
      vic_rank_r   <= '0;
    end else begin
      cmp_vld_r <= cmd.scan;
      if (cmd.start) begin
        idx_r        <= '0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
        vic_seen_r   <= 1'b0;
      end else begin
        if (cmd.scan) begin
          idx_r <= idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (cur_valid) begin
            if (!hit_found_r && tag_eq) begin
              hit_found_r <= 1'b1;
              hit_idx_r   <= cmp_idx_r;
              hit_rank_r  <= cur_rank;
            end
            if (!vic_seen_r || cur_rank > vic_rank_r) begin
              vic_seen_r <= 1'b1;
              vic_idx_r  <= cmp_idx_r;
              vic_rank_r <= cur_rank;
            end
          end else if (!free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= cmp_idx_r;
          end
        end
      end
    end
  end

  // entry state and miss counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ltlb_pkg::ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
      miss_cnt_r <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < ltlb_pkg::ENTRIES; i++) begin
        if (ltlb_pkg::IDX_BITS'(i) == slot) begin
          valid_r[i] <= 1'b1;
          rank_r[i]  <= '0;
        end else if (valid_r[i] && (!hit_found_r || rank_r[i] < hit_rank_r)) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
      if (!hit_found_r && miss_cnt_r != ltlb_pkg::CNT_MAX) begin
        miss_cnt_r <= miss_cnt_r + 1'b1;
      end
    end
  end

  assign out_was_hit      = out_hit_r;
  assign out_total_misses = out_cnt_r;

`ifndef SYNTHESIS
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.update |=> $stable(miss_cnt_r))
    else $error("miss counter changed outside update");

  a_slot_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (hit_found_r || free_found_r || vic_seen_r))
    else $error("update with no target slot");

  a_victim_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && !hit_found_r && !free_found_r |-> vic_rank_r == ltlb_pkg::OLDEST_RANK)
    else $error("evicted entry is not least recently used");
`endif

endmodule

/* design/ltlb_ctrl.sv */
// ltlb_ctrl: sequencing FSM for one lookup (accept, scan, update, deliver) and output valid.
// Depends on ltlb_pkg; commands ltlb_dp.
module ltlb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output ltlb_pkg::cmd_t  cmd,
  input  ltlb_pkg::stat_t stat
);

  ltlb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltlb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      ltlb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ltlb_pkg::ST_SCAN;
        end
      end
      ltlb_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ltlb_pkg::ST_DRAIN;
        end
      end
      ltlb_pkg::ST_DRAIN: begin
        state_nxt = ltlb_pkg::ST_UPDATE;
      end
      ltlb_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ltlb_pkg::ST_DONE;
      end
      ltlb_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ltlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ltlb_pkg::ST_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_scan_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> cmd.scan)
    else $error("scan did not follow accepted item");
`endif

endmodule

/* design/lru_tlb_miss_counter_core.sv */
// lru_tlb_miss_counter_core: top level of the fully associative LRU TLB miss counter.
// Depends on ltlb_pkg, ltlb_ctrl, ltlb_dp (which holds ltlb_ram).
//
//   channel  handshake            payload
//   in       in_valid/in_stall    in_byte_address[47:0]
//   out      out_valid/out_stall  out_was_hit, out_total_misses[31:0]
//
// An item is accepted, then the tag RAM scan reads one entry per cycle without stalling,
// then a drain, update and delivery step follow; a new item is taken only after delivery.
// Synchronous active-low reset clears valid bits, ranks and the miss counter at once.
// The output register holds a result under out_stall; a new item is accepted meanwhile
// and waits in the delivery step until that result is taken.
module lru_tlb_miss_counter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ltlb_pkg::ADDR_BITS-1:0] in_byte_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_was_hit,
  output logic [ltlb_pkg::CNT_BITS-1:0]  out_total_misses
);

  ltlb_pkg::cmd_t  cmd;
  ltlb_pkg::stat_t stat;

  ltlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ltlb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_byte_address  (in_byte_address),
    .out_was_hit      (out_was_hit),
    .out_total_misses (out_total_misses)
  );

endmodule
